/* rtl/multichannel_sine_crossfade_gate_unit_macros.svh */
// Assertion macros used by the back part of the crossfade gate RTL.
`ifndef MULTICHANNEL_SINE_CROSSFADE_GATE_UNIT_MACROS_SVH
`define MULTICHANNEL_SINE_CROSSFADE_GATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MSCG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("crossfade gate assertion failed");

// Next-cycle implication, disabled during reset.
`define MSCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("crossfade gate assertion failed");

`endif

/* rtl/mscg_pkg.sv */
// Shared types, constants and the sine table function of the crossfade gate.
package mscg_pkg;

  localparam int MAX_CHANNELS_DEF    = 8;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int POS_W       = 32;
  localparam int WIDTH_W     = 25;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [23:0] SPREAD_MIN = 24'd6554;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  typedef enum logic [0:0] {
    REG_INDEX_MODE    = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0]      sample;
    logic signed [POS_W-1:0] pos;
    logic [WIDTH_W-1:0]      width;
  } entry_t;

  // Unsigned Q0.15 value of sin(pi*k/2^bits) for k up to half the table, from a Q30 Taylor series.
  function automatic logic [14:0] sine_value(int unsigned k, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    longint      sum;
    longint      r;
    x    = (PI_Q30 * 64'(k)) >> bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int i = 1; i <= 5; i++) begin
      prod = (term * x2) >> 30;
      case (i)
        1:       term = prod / 64'd6;
        2:       term = prod / 64'd20;
        3:       term = prod / 64'd42;
        4:       term = prod / 64'd72;
        default: term = prod / 64'd110;
      endcase
      if ((i % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (sum + 64'sd16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return 15'(r);
  endfunction

endpackage

/* rtl/mscg_front.sv */
// Front part: takes input items, clamps the spread and forms position and window width.
module mscg_front #(
  parameter int MAX_CHANNELS = mscg_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [15:0]                   sample_in,
  input  logic signed [23:0]                   position,
  input  logic [23:0]                          spread_in,
  input  logic                                 index_mode,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]    cnt,
  input  logic                                 q_full,
  output logic                                 q_push,
  output mscg_pkg::entry_t                     q_data
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);

  logic                             f_valid;
  mscg_pkg::entry_t                 f_entry;
  logic                             accept;
  logic [CW-1:0]                    cm1;
  logic [23:0]                      spread_c;
  logic signed [24+CW:0]            scaled;
  logic signed [mscg_pkg::POS_W-1:0] pos_sel;
  logic signed [mscg_pkg::POS_W-1:0] pos;

  assign accept   = push && !full;
  assign full     = f_valid && q_full;
  assign q_push   = f_valid && !q_full;
  assign q_data   = f_entry;

  assign cm1      = cnt - CW'(1);
  assign spread_c = (spread_in < mscg_pkg::SPREAD_MIN) ? mscg_pkg::SPREAD_MIN : spread_in;
  assign scaled   = position * $signed({1'b0, cm1});
  assign pos_sel  = index_mode ? mscg_pkg::POS_W'(position) : mscg_pkg::POS_W'(scaled);
  assign pos      = pos_sel + $signed({8'b0, spread_c});

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.sample <= sample_in;
      f_entry.pos    <= pos;
      f_entry.width  <= {spread_c, 1'b0};
    end
  end

endmodule

/* rtl/mscg_fifo.sv */
// Short queue of prepared items between the front and back parts.
module mscg_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mscg_pkg::entry_t data_in,
  output logic             full,
  input  logic             pop,
  output mscg_pkg::entry_t data_out,
  output logic             empty
);

  mscg_pkg::entry_t               mem [mscg_pkg::QUEUE_DEPTH];
  logic [mscg_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [mscg_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [mscg_pkg::QUEUE_AW:0]    fill;
  logic                           do_push;
  logic                           do_pop;

  assign full     = fill == (mscg_pkg::QUEUE_AW + 1)'(mscg_pkg::QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

endmodule

/* rtl/mscg_back.sv */
// Back part: walks the channels of each item through a divider, sine table and multiplier.
`include "multichannel_sine_crossfade_gate_unit_macros.svh"

module mscg_back #(
  parameter int MAX_CHANNELS    = mscg_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_TABLE_BITS = mscg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0] cnt,
  input  mscg_pkg::entry_t                  head,
  input  logic                              head_valid,
  output logic                              head_pop,
  output logic [2:0]                        channel,
  output logic signed [15:0]                sample_out,
  output logic                              last,
  output logic                              empty,
  input  logic                              pop
);

  localparam int CW      = $clog2(MAX_CHANNELS + 1);
  localparam int JW      = $clog2(MAX_CHANNELS);
  localparam int STB     = SINE_TABLE_BITS;
  localparam int HALF    = 1 << (STB - 1);
  localparam int ROM_IDX = STB + 1;
  localparam int OUT_IDX = STB + 3;
  localparam int DEPTH   = STB + 4;
  localparam int POS_W   = mscg_pkg::POS_W;
  localparam int WW      = mscg_pkg::WIDTH_W;
  localparam logic [STB-1:0] HALF_K = STB'(HALF);

  typedef struct packed {
    logic                valid;
    logic                win;
    logic                last;
    logic [JW-1:0]       j;
    logic signed [15:0]  sample;
  } side_t;

  side_t               pipe [DEPTH];
  logic [JW-1:0]       j_cnt;
  logic                adv;
  logic                issue;
  logic                issue_last;
  logic [POS_W-1:0]    j_off;
  logic [POS_W:0]      dfull;
  logic                win0;
  logic [WW-1:0]       rem [STB+1];
  logic [STB-1:0]      quo [STB+1];
  logic [WW-1:0]       wid [STB+1];
  logic [WW-1:0]       rem_nx [1:STB];
  logic                ge_nx [1:STB];
  logic [STB-1:0]      k;
  logic [STB-1:0]      neg_k;
  logic [STB-1:0]      kf;
  logic [14:0]         rom [HALF+1];
  logic [14:0]         gain;
  logic signed [31:0]  prod;
  logic signed [31:0]  rnd;
  logic signed [15:0]  y;

  assign adv        = !pipe[OUT_IDX].valid || pop;
  assign issue      = adv && head_valid;
  assign issue_last = CW'(j_cnt) == (cnt - CW'(1));
  assign head_pop   = issue && issue_last;

  assign j_off = POS_W'(j_cnt) << 16;
  assign dfull = {head.pos[POS_W-1], head.pos} - {1'b0, j_off};
  assign win0  = !dfull[POS_W] && (dfull[POS_W-1:0] < POS_W'(head.width));

  for (genvar gs = 1; gs <= STB; gs++) begin : g_div
    logic [WW:0] dbl;
    assign dbl        = {rem[gs-1], 1'b0};
    assign ge_nx[gs]  = dbl >= {1'b0, wid[gs-1]};
    assign rem_nx[gs] = ge_nx[gs] ? WW'(dbl - {1'b0, wid[gs-1]}) : WW'(dbl);
  end

  for (genvar gr = 0; gr <= HALF; gr++) begin : g_rom
    assign rom[gr] = mscg_pkg::sine_value(gr, STB);
  end

  assign k     = quo[STB];
  assign neg_k = -k;
  assign kf    = (k > HALF_K) ? neg_k : k;
  assign rnd   = prod + 32'sd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_cnt <= '0;
    end else if (issue) begin
      j_cnt <= issue_last ? '0 : j_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe[i].valid <= 1'b0;
      end
    end else if (adv) begin
      pipe[0].valid  <= issue;
      pipe[0].win    <= win0;
      pipe[0].last   <= issue_last;
      pipe[0].j      <= j_cnt;
      pipe[0].sample <= head.sample;
      for (int i = 1; i < DEPTH; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= dfull[WW-1:0];
      quo[0] <= '0;
      wid[0] <= head.width;
      for (int i = 1; i <= STB; i++) begin
        rem[i] <= rem_nx[i];
        quo[i] <= {quo[i-1][STB-2:0], ge_nx[i]};
        wid[i] <= wid[i-1];
      end
      gain <= pipe[STB].win ? rom[kf] : '0;
      prod <= pipe[ROM_IDX].sample * $signed({1'b0, gain});
      y    <= rnd[30:15];
    end
  end

  assign empty      = !pipe[OUT_IDX].valid;
  assign channel    = 3'(pipe[OUT_IDX].j);
  assign last       = pipe[OUT_IDX].last;
  assign sample_out = y;

  `MSCG_ASSERT_IMPLY(a_gain_zero_outside, clk, rst, pipe[ROM_IDX].valid && !pipe[ROM_IDX].win, gain == '0)
  `MSCG_ASSERT_NEXT(a_channel_step, clk, rst, issue && !issue_last, j_cnt == JW'($past(j_cnt) + 1'b1))
  `MSCG_ASSERT_IMPLY(a_fold_range, clk, rst, pipe[STB].valid, kf <= HALF_K)

endmodule

/* rtl/multichannel_sine_crossfade_gate_unit.sv */
// Top level of the multichannel sine crossfade gate with its configuration registers.
// Throughput: one result per cycle while popped, channel_count results per item (two to MAX_CHANNELS).
// The back part sets the pace: it issues one channel a cycle into its divider pipeline unless stalled.
// Reset is synchronous and active high; it sets index_mode to 0, channel_count to 2, and empties
// the queue and pipeline.
module multichannel_sine_crossfade_gate_unit #(
  parameter int MAX_CHANNELS    = mscg_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_TABLE_BITS = mscg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [0:0]         cfg_index,
  input  logic [3:0]         cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_in,
  input  logic signed [23:0] position,
  input  logic [23:0]        spread_in,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         channel,
  output logic signed [15:0] sample_out,
  output logic               last
);

  localparam int CW = $clog2(MAX_CHANNELS + 1);

  logic             index_mode;
  logic [3:0]       channel_count;
  logic [CW-1:0]    cnt;
  logic             q_full;
  logic             q_push;
  logic             q_empty;
  logic             q_pop;
  mscg_pkg::entry_t q_in;
  mscg_pkg::entry_t q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_mode    <= 1'b0;
      channel_count <= 4'd2;
    end else if (cfg_write) begin
      case (mscg_pkg::reg_index_t'(cfg_index))
        mscg_pkg::REG_INDEX_MODE:    index_mode    <= cfg_data[0];
        mscg_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cnt = (channel_count < 4'd2) ? CW'(2) :
               (int'(channel_count) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(channel_count);

  mscg_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample_in  (sample_in),
    .position   (position),
    .spread_in  (spread_in),
    .index_mode (index_mode),
    .cnt        (cnt),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  mscg_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .data_out (q_head),
    .empty    (q_empty)
  );

  mscg_back #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cnt        (cnt),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .channel    (channel),
    .sample_out (sample_out),
    .last       (last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

/* verif/multichannel_sine_crossfade_gate_unit_test.sv */
// Self-checking testbench for the multichannel sine crossfade gate unit.
`timescale 1ns / 100ps

module multichannel_sine_crossfade_gate_unit_test;

  localparam int SINE_BITS         = mscg_pkg::SINE_TABLE_BITS_DEF;
  localparam int CHANNELS          = mscg_pkg::MAX_CHANNELS_DEF;
  localparam int NUM_SETTINGS      = 12;
  localparam int ITEMS_PER_SETTING = 17;
  localparam int HOLD_CYCLES       = 300;
  localparam int DRAIN_CYCLES      = 40;
  localparam int STALL_LIMIT       = 2000;
  localparam longint unsigned MIN_SPREAD = 6554;

  typedef struct packed {
    logic [2:0]  channel;
    logic [15:0] sample;
    logic        last;
  } weighted_t;

  class crossfade_scoreboard;
    weighted_t   weighted_q[$];
    int          errors;
    int          checked;
    bit          index_mode;
    logic [3:0]  count_reg;

    function new();
      errors     = 0;
      checked    = 0;
      index_mode = 1'b0;
      count_reg  = 4'd2;
    endfunction

    function void write_reg(mscg_pkg::reg_index_t idx, logic [3:0] value);
      if (idx == mscg_pkg::REG_INDEX_MODE) begin
        index_mode = value[0];
      end else begin
        count_reg = value;
      end
    endfunction

    function int active_count();
      if (count_reg < 2) begin
        return 2;
      end
      if (count_reg > CHANNELS) begin
        return CHANNELS;
      end
      return count_reg;
    endfunction

    function int pending();
      return weighted_q.size();
    endfunction

    // Half-sine window value in Q1.15 at table step k of 2^SINE_BITS.
    function logic [15:0] window_gain(longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      longint          r;
      if (k > (1 << (SINE_BITS - 1))) begin
        k = (1 << SINE_BITS) - k;
      end
      x    = (mscg_pkg::PI_Q30 * k) >> SINE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int i = 1; i <= 5; i++) begin
        term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      r = (acc + 16384) >>> 15;
      if (r > 32767) begin
        r = 32767;
      end
      return 16'(r);
    endfunction

    function void note_item(logic signed [15:0] s, logic signed [23:0] p, logic [23:0] sp);
      longint      smp;
      longint      spread;
      longint      center;
      longint      span;
      longint      d;
      longint      y;
      logic [15:0] gain;
      int          n;
      weighted_t   w;
      n      = active_count();
      smp    = longint'(s);
      spread = longint'(sp);
      if (spread < MIN_SPREAD) begin
        spread = MIN_SPREAD;
      end
      center = index_mode ? longint'(p) : longint'(p) * longint'(n - 1);
      center = center + spread;
      span   = 2 * spread;
      for (int j = 0; j < n; j++) begin
        d    = center - longint'(j) * 65536;
        gain = 16'd0;
        if (d >= 0 && d < span) begin
          gain = window_gain(longint'(unsigned'((d << SINE_BITS) / span)));
        end
        y         = (smp * longint'(gain) + 16384) >>> 15;
        w.channel = 3'(j);
        w.sample  = 16'(y);
        w.last    = (j == n - 1);
        weighted_q.push_back(w);
      end
    endfunction

    function void check_result(logic [2:0] ch, logic [15:0] smp, logic lst);
      weighted_t w;
      if (weighted_q.size() == 0) begin
        $display("%0t: unexpected item: channel %0d sample %0d last %0b",
                 $time, ch, $signed(smp), lst);
        errors++;
        return;
      end
      w = weighted_q.pop_front();
      checked++;
      if (ch !== w.channel) begin
        $display("%0t: channel mismatch: expected %0d, actual %0d", $time, w.channel, ch);
        errors++;
      end
      if (smp !== w.sample) begin
        $display("%0t: sample_out mismatch on channel %0d: expected %0d, actual %0d",
                 $time, w.channel, $signed(w.sample), $signed(smp));
        errors++;
      end
      if (lst !== w.last) begin
        $display("%0t: last mismatch on channel %0d: expected %0b, actual %0b",
                 $time, w.channel, w.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cfg_write  = 1'b0;
  logic [0:0]         cfg_index  = mscg_pkg::REG_INDEX_MODE;
  logic [3:0]         cfg_data   = 4'd0;
  logic               push       = 1'b0;
  logic signed [15:0] sample_in  = 16'sd0;
  logic signed [23:0] position   = 24'sd0;
  logic [23:0]        spread_in  = 24'd0;
  logic               pop        = 1'b0;
  logic               full;
  logic               empty;
  logic [2:0]         channel;
  logic signed [15:0] sample_out;
  logic               last;

  crossfade_scoreboard sb;
  bit                  steady   = 1'b0;
  bit                  hold_req = 1'b0;
  int                  items_sent = 0;
  int                  stall_count = 0;

  logic [3:0] mode_tab  [NUM_SETTINGS] = '{4'd0, 4'd1, 4'd1, 4'b1110, 4'd1, 4'd0,
                                           4'b0011, 4'd0, 4'd1, 4'd0, 4'd1, 4'd0};
  logic [3:0] count_tab [NUM_SETTINGS] = '{4'd8, 4'd8, 4'd2, 4'd0, 4'd15, 4'd5,
                                           4'd1, 4'd6, 4'd9, 4'd3, 4'd7, 4'd4};

  multichannel_sine_crossfade_gate_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sample_in (sample_in),
    .position  (position),
    .spread_in (spread_in),
    .empty     (empty),
    .pop       (pop),
    .channel   (channel),
    .sample_out(sample_out),
    .last      (last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("multichannel_sine_crossfade_gate_unit test failed");
      $finish;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        sb.check_result(channel, sample_out, last);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 34);
      end
    end
  end

  task automatic offer(input logic signed [15:0] s, input logic signed [23:0] p,
                       input logic [23:0] sp);
    while (!steady && $urandom_range(99) < 34) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    sample_in <= s;
    position  <= p;
    spread_in <= sp;
    do @(posedge clk); while (full);
    sb.note_item(s, p, sp);
    items_sent++;
  endtask

  task automatic random_item();
    int          n;
    logic [15:0] s;
    logic [23:0] p;
    logic [23:0] sp;
    n = sb.active_count();
    s = 16'($urandom);
    if ($urandom_range(9) == 0) begin
      s = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    end
    if ($urandom_range(99) < 70) begin
      sp = ($urandom_range(9) == 0) ? 24'($urandom_range(0, 6554))
                                    : 24'($urandom_range(6554, 196608));
      if (sb.index_mode) begin
        p = 24'($urandom_range(0, (n + 1) * 65536) - 65536);
      end else begin
        p = 24'($urandom_range(0, 81920) - 8192);
      end
    end else begin
      p  = 24'($urandom);
      sp = 24'($urandom);
    end
    offer(s, p, sp);
  endtask

  task automatic write_setting(input logic [3:0] mode_val, input logic [3:0] count_val);
    cfg_write <= 1'b1;
    cfg_index <= mscg_pkg::REG_INDEX_MODE;
    cfg_data  <= mode_val;
    @(posedge clk);
    sb.write_reg(mscg_pkg::REG_INDEX_MODE, mode_val);
    cfg_index <= mscg_pkg::REG_CHANNEL_COUNT;
    cfg_data  <= count_val;
    @(posedge clk);
    sb.write_reg(mscg_pkg::REG_CHANNEL_COUNT, count_val);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    offer(16'sh7fff, 24'sd0, 24'd0);
    offer(-16'sh8000, 24'sd0, 24'd6553);
    offer(-16'sh8000, 24'sd65536, 24'd6554);
    offer(16'sh7fff, 24'sd32768, 24'd65536);
    offer(16'sh7fff, -24'sh800000, 24'hffffff);
    offer(-16'sh8000, 24'sh7fffff, 24'd0);
    offer(16'sd12345, 24'sh7fffff, 24'hffffff);
    offer(16'sh7fff, -24'sd32768, 24'd32768);
    offer(-16'sd1, 24'sd0, 24'd65536);
    offer(16'sh7fff, 24'sd65536, 24'd65536);
    offer(-16'sh8000, -24'sd6554, 24'd6554);
    offer(16'sd1, 24'sd16384, 24'd24576);
    push <= 1'b0;

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      wait_drained();
      write_setting(mode_tab[ph], count_tab[ph]);
      if (ph == 1) begin
        offer(16'sh7fff, 24'sd0, 24'd65536);
        offer(-16'sh8000, 24'sd458752, 24'd6554);
        offer(16'sh7fff, 24'sd203161, 24'd6554);
        offer(-16'sh8000, 24'sd124518, 24'd6554);
        offer(16'sd20000, -24'sd65536, 24'd131072);
        offer(16'sh7fff, 24'sd327680, 24'd0);
        offer(-16'sd12345, 24'sd294912, 24'd49152);
        offer(16'sh7fff, 24'sh7fffff, 24'hffffff);
      end
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      steady = (ph == 5);
      repeat (ITEMS_PER_SETTING) random_item();
      push <= 1'b0;
    end
    wait_drained();
    steady = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d weighted samples over %0d register settings,",
             items_sent, sb.checked, NUM_SETTINGS + 1);
    $display("covering both position modes, clamped spreads and clamped channel counts.");
    if (sb.errors == 0) begin
      $display("multichannel_sine_crossfade_gate_unit test passed");
    end else begin
      $display("multichannel_sine_crossfade_gate_unit test failed");
    end
    $finish;
  end

endmodule
